[src/bads_pkg.sv]
// Shared constants, types and the queue record for the block average downsampler.
// No dependencies; every other file except bads_ram uses this package.
package bads_pkg;

  // Image and block geometry (BLOCK_SIDE must be a power of two)
  localparam int IMAGE_WIDTH  = 256;
  localparam int IMAGE_HEIGHT = 256;
  localparam int BLOCK_SIDE   = 4;

  localparam int SIDE_LOG2 = $clog2(BLOCK_SIDE);
  localparam int FULL_COLS = IMAGE_WIDTH / BLOCK_SIDE;
  localparam int FULL_ROWS = IMAGE_HEIGHT / BLOCK_SIDE;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int VALUE_W = 9;
  localparam int TAG_W   = 6;
  localparam int MEAN_W  = PIX_W;
  localparam int SUM_W   = PIX_W + 2 * SIDE_LOG2;

  // Position counters
  localparam int COL_W = $clog2(IMAGE_WIDTH);
  localparam int ROW_W = $clog2(IMAGE_HEIGHT);
  localparam int CX_W  = COL_W + TAG_W;
  localparam int RX_W  = ROW_W + TAG_W;

  // Column sum store
  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One classified pixel on its way to the accumulator
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [SLOT_W-1:0] slot;
    logic              first;
    logic              last;
    logic [TAG_W-1:0]  block_row;
    logic [TAG_W-1:0]  block_col;
    logic              frame_done;
  } bads_item_t;

  // Queue occupancy seen by both sides
  typedef struct packed {
    logic full;
    logic valid;
  } bads_q_stat_t;

endpackage

[src/bads_if.sv]
// Valid/ready channel interfaces for pixels in and block results out.
// Depends on bads_pkg for field widths.
interface bads_in_if;
  logic                       valid;
  logic                       ready;
  logic [bads_pkg::PIX_W-1:0] pixel;
  logic                       frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface bads_out_if;
  logic                         valid;
  logic                         ready;
  logic [bads_pkg::VALUE_W-1:0] block_value;
  logic [bads_pkg::TAG_W-1:0]   block_row;
  logic [bads_pkg::TAG_W-1:0]   block_col;
  logic                         frame_done;

  modport source (output valid, output block_value, output block_row, output block_col,
                  output frame_done, input ready);
  modport sink   (input valid, input block_value, input block_row, input block_col,
                  input frame_done, output ready);
endinterface

[src/bads_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module bads_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port; read returns the old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

[src/bads_front.sv]
// Front end: pixel position counters and block classification of each request.
// Depends on bads_pkg and bads_in_if.
module bads_front (
  input  logic                   clk,
  input  logic                   rst_n,
  bads_in_if.sink                in_chan,
  input  bads_pkg::bads_q_stat_t q_stat,
  output logic                   q_push,
  output bads_pkg::bads_item_t   q_item
);
  import bads_pkg::*;

  logic [COL_W-1:0]     col_r, col_nxt, col_cur;
  logic [ROW_W-1:0]     row_r, row_nxt, row_cur;
  logic [CX_W-1:0]      bcol_ext;
  logic [RX_W-1:0]      brow_ext;
  logic [SIDE_LOG2-1:0] cin, rin;
  logic                 in_range;
  logic                 accept;

  // Take a request whenever the queue has room
  assign in_chan.ready = !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;

  // Classify the current pixel
  always_comb begin
    col_cur  = in_chan.frame_start ? '0 : col_r;
    row_cur  = in_chan.frame_start ? '0 : row_r;
    bcol_ext = {{TAG_W{1'b0}}, col_cur} >> SIDE_LOG2;
    brow_ext = {{TAG_W{1'b0}}, row_cur} >> SIDE_LOG2;
    cin      = col_cur[SIDE_LOG2-1:0];
    rin      = row_cur[SIDE_LOG2-1:0];
    in_range = (bcol_ext < CX_W'(FULL_COLS)) && (brow_ext < RX_W'(FULL_ROWS));

    q_item.pixel      = in_chan.pixel;
    q_item.slot       = bcol_ext[SLOT_W-1:0];
    q_item.first      = (cin == '0) && (rin == '0);
    q_item.last       = (&cin) && (&rin);
    q_item.block_row  = brow_ext[TAG_W-1:0];
    q_item.block_col  = bcol_ext[TAG_W-1:0];
    q_item.frame_done = (bcol_ext == CX_W'(FULL_COLS - 1))
                     && (brow_ext == RX_W'(FULL_ROWS - 1));
  end

  // Drop pixels outside the full blocks; they only advance the position
  assign q_push = accept && in_range;

  // Advance raster position, wrapping at line and frame end
  always_comb begin
    if (col_cur == COL_W'(IMAGE_WIDTH - 1)) begin
      col_nxt = '0;
      row_nxt = (row_cur == ROW_W'(IMAGE_HEIGHT - 1)) ? '0 : row_cur + 1'b1;
    end else begin
      col_nxt = col_cur + 1'b1;
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end
endmodule

[src/bads_queue.sv]
// Short FIFO of classified pixels between the front end and the accumulator.
// Depends on bads_pkg.
module bads_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  bads_pkg::bads_item_t   push_item,
  input  logic                   pop,
  output bads_pkg::bads_q_stat_t q_stat,
  output bads_pkg::bads_item_t   head
);
  import bads_pkg::*;

  bads_item_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.valid = (cnt_r != '0);
  assign head         = mem_r[rd_ptr_r];

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

[src/bads_back.sv]
// Back end: column sum read-modify-write with forwarding, mean and result register.
// Depends on bads_pkg, bads_out_if and bads_ram.
module bads_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bads_pkg::bads_q_stat_t q_stat,
  input  bads_pkg::bads_item_t   q_head,
  output logic                   q_pop,
  bads_out_if.source             out_chan
);
  import bads_pkg::*;

  logic               s_valid_r;
  bads_item_t         s_item_r;
  logic               s_fwd_hit_r;
  logic [SUM_W-1:0]   s_fwd_data_r;
  logic [SUM_W-1:0]   rd_sum, old_sum, new_sum;
  logic [MEAN_W-1:0]  mean;
  logic               s_fire, s_load, out_free;

  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [TAG_W-1:0]   out_row_r, out_col_r;
  logic               out_done_r;

  // Column sum store
  bads_ram #(.WIDTH(SUM_W), .DEPTH(SLOTS)) u_sums (
    .clk   (clk),
    .we    (s_fire),
    .waddr (s_item_r.slot),
    .wdata (new_sum),
    .re    (s_load),
    .raddr (q_head.slot),
    .rdata (rd_sum)
  );

  // Handshake between queue, accumulate stage and result register
  assign out_free = !out_valid_r || out_chan.ready;
  assign s_fire   = s_valid_r && (!s_item_r.last || out_free);
  assign s_load   = q_stat.valid && (!s_valid_r || s_fire);
  assign q_pop    = s_load;

  // Accumulate; take the sum written in the same cycle as our read
  always_comb begin
    old_sum = s_fwd_hit_r ? s_fwd_data_r : rd_sum;
    new_sum = s_item_r.first ? SUM_W'(s_item_r.pixel) : old_sum + SUM_W'(s_item_r.pixel);
    mean    = new_sum[SUM_W-1:2*SIDE_LOG2];
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (s_load) begin
      s_valid_r <= 1'b1;
    end else if (s_fire) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_load) begin
      s_item_r     <= q_head;
      s_fwd_hit_r  <= s_fire && (s_item_r.slot == q_head.slot);
      s_fwd_data_r <= new_sum;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s_fire && s_item_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_item_r.last) begin
      out_value_r <= {mean, 1'b0};
      out_row_r   <= s_item_r.block_row;
      out_col_r   <= s_item_r.block_col;
      out_done_r  <= s_item_r.frame_done;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.block_value = out_value_r;
  assign out_chan.block_row   = out_row_r;
  assign out_chan.block_col   = out_col_r;
  assign out_chan.frame_done  = out_done_r;
endmodule

[src/block_average_downsampler.sv]
// Block average downsampler: one pixel request per cycle while the output is ready, set
// by the single read-modify-write of the column sum RAM (one read and one write port,
// forwarded). A block result passes the queue, accumulate stage and result register.
// Reset (rst_n, synchronous) clears the raster position, queue and valid flags only;
// the 64-entry column sum RAM is not cleared, as each sum is seeded by its first pixel.
// Depends on bads_pkg, bads_if, bads_front, bads_queue, bads_back.
module block_average_downsampler (
  input logic         clk,
  input logic         rst_n,
  bads_in_if.sink     in_chan,
  bads_out_if.source  out_chan
);
  import bads_pkg::*;

  bads_q_stat_t q_stat;
  bads_item_t   q_item, q_head;
  logic         q_push, q_pop;

  // Classify pixels
  bads_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_item  (q_item)
  );

  // Decouple front and back
  bads_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .q_stat    (q_stat),
    .head      (q_head)
  );

  // Accumulate and emit block means
  bads_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  // A frame start always lands in the top-left block and must be queued
  a_start_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && in_chan.frame_start |-> q_push)
    else $error("frame start pixel not queued");

  // The frame's last block is tagged with the last block row and column
  a_done_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.frame_done |->
      (out_chan.block_col == TAG_W'(FULL_COLS - 1))
      && (out_chan.block_row == TAG_W'(FULL_ROWS - 1)))
    else $error("frame done on wrong block");

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !q_push || q_pop)
    else $error("queue overflow");
endmodule
